// ----- src/lccb_pkg.sv -----
// Package for the LED color crossfade block: opcodes, register indexes,
// sequencer states, request structs and fixed widths.
// No dependencies.
`default_nettype none

package lccb_pkg;

    // fixed field widths
    localparam int COLOR_W    = 8;
    localparam int COUNT_W    = 16;
    localparam int WEIGHT_W   = 9;
    localparam int BEAT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;
    localparam int OP_W       = 2;

    // divider produces one quotient bit per step
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // constants of the color math
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
    localparam logic [COLOR_W-1:0]  LEVEL_MAX   = 8'd255;
    localparam logic [BEAT_W-1:0]   BEAT_START  = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_EVAL    = 2'd0,
        OP_TICK    = 2'd1,
        OP_BEAT    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_STEPS  = 2'd0,
        CFG_HOST_MODE     = 2'd1,
        CFG_BEAT_ENABLED  = 2'd2,
        CFG_IGNORE_PERIOD = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QDIV,
        ST_WEIGHT,
        ST_EDIV,
        ST_BLEND,
        ST_FLASH,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_DONE
    } state_t;

    // request to the shared divider: num < den, quotient = num*256/den
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] num;
        logic [COUNT_W-1:0] den;
    } div_req_t;

    // operands of the shared multiply-add: (w0*x + w1*y) >> 8
    typedef struct packed {
        logic [WEIGHT_W-1:0] w0;
        logic [COLOR_W-1:0]  x;
        logic [WEIGHT_W-1:0] w1;
        logic [COLOR_W-1:0]  y;
    } mix_op_t;

endpackage

`default_nettype wire

// ----- src/led_color_crossfade_beat.sv -----
// Top level of the LED color crossfade block: sequencer, strip step memory,
// configuration registers and output register. Uses lccb_pkg, lccb_div, lccb_mix.
`default_nettype none

// One request is taken at a time; s_axis_tready is high only while the sequencer
// is idle, and a finished result waits in the output register without blocking
// the next request. An evaluate passes at most twice through the shared divider
// (eight quotient steps and a done strobe each, for the green indicator level
// and the crossfade weight), picks the weight, sends each color channel through
// the shared multiply-add for the blend and then the flash, and hands off the
// result. A tick walks the strip step memory with one read and one write per
// strip; beat and restart go straight to the hand-off. Configuration must be
// written by the user through cfg_we/cfg_index/cfg_data only while no request
// is in flight; the block itself has no logic that enforces this.

module led_color_crossfade_beat
    import lccb_pkg::*;
#(
    parameter int STRIP_COUNT = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // strip_index, start_red, start_green, start_blue, end_red, end_green,
    // end_blue, ignore_count, zero pad
    input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  wire logic [OP_W-1:0]         s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // out_red, out_green, out_blue
    output logic [OUT_DATA_W-1:0]        m_axis_tdata,
    // mood_wrap
    output logic                         m_axis_tuser
);

    localparam int SW = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
    localparam logic [SW-1:0] LAST_STRIP = SW'(STRIP_COUNT - 1);

    // configuration registers
    logic [COLOR_W-1:0]  smooth_steps_reg;
    logic                host_mode_reg;
    logic                beat_enabled_reg;
    logic [COUNT_W-1:0]  ignore_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_steps_reg  <= '0;
            host_mode_reg     <= 1'b1;
            beat_enabled_reg  <= 1'b0;
            ignore_period_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SMOOTH_STEPS:  smooth_steps_reg  <= cfg_data[COLOR_W-1:0];
                CFG_HOST_MODE:     host_mode_reg     <= cfg_data[0];
                CFG_BEAT_ENABLED:  beat_enabled_reg  <= cfg_data[0];
                CFG_IGNORE_PERIOD: ignore_period_reg <= cfg_data;
                default:           host_mode_reg     <= host_mode_reg;
            endcase
        end
    end

    // input fields
    logic [2:0]          in_idx;
    logic [47:0]         in_colors;
    logic [COUNT_W-1:0]  in_count;
    logic                in_idx_ok;
    logic                s_accept;

    assign in_idx    = s_axis_tdata[2:0];
    assign in_colors = s_axis_tdata[50:3];
    assign in_count  = s_axis_tdata[66:51];
    assign in_idx_ok = (32'(in_idx) < STRIP_COUNT);
    assign s_accept  = s_axis_tvalid && s_axis_tready;

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [2:0]          idx_reg, idx_next;
    logic                idx_ok_reg, idx_ok_next;
    logic [47:0]         colors_reg, colors_next;
    logic [WEIGHT_W-1:0] e_reg, e_next;
    logic [COLOR_W-1:0]  c_reg, c_next;
    logic [1:0]          ch_reg, ch_next;
    logic [COLOR_W-1:0]  red_reg, red_next;
    logic [COLOR_W-1:0]  green_reg, green_next;
    logic [COLOR_W-1:0]  blue_reg, blue_next;
    logic                wrap_reg, wrap_next;
    logic [SW-1:0]       ptr_reg, ptr_next;
    logic [BEAT_W-1:0]   beat_reg, beat_next;
    logic [COLOR_W-1:0]  phase_reg, phase_next;
    logic                half_reg, half_next;
    logic [STRIP_COUNT-1:0] strip_valid_reg, strip_valid_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    // strip step memory
    logic [COLOR_W-1:0]  step_mem [STRIP_COUNT];
    logic [COLOR_W-1:0]  rd_data_reg;
    logic                rd_valid_reg;
    logic [SW-1:0]       rd_addr;
    logic                mem_we;
    logic [SW-1:0]       mem_waddr;
    logic [COLOR_W-1:0]  mem_wdata;

    // shared units
    div_req_t            div_req;
    logic                div_done;
    logic [DIV_STEPS-1:0] div_quot;
    mix_op_t             mix_op;
    logic [COLOR_W-1:0]  mix_res;

    // operand helpers
    logic [COLOR_W-1:0]  step_val;
    logic [COLOR_W-1:0]  start_ch;
    logic [COLOR_W-1:0]  end_ch;
    logic [WEIGHT_W-1:0] lift;

    lccb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    lccb_mix u_mix
    (
        .op  (mix_op),
        .res (mix_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            step_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= step_mem[rd_addr];
    end

    // channel operand selection and flash weight
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                start_ch = colors_reg[7:0];
                end_ch   = colors_reg[31:24];
            end
            2'd1:
            begin
                start_ch = colors_reg[15:8];
                end_ch   = colors_reg[39:32];
            end
            default:
            begin
                start_ch = colors_reg[23:16];
                end_ch   = colors_reg[47:40];
            end
        endcase
        lift     = beat_enabled_reg ? WEIGHT_W'({beat_reg, 1'b0}) : '0;
        step_val = rd_valid_reg ? rd_data_reg : '0;
    end

    // next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        idx_ok_next      = idx_ok_reg;
        colors_next      = colors_reg;
        e_next           = e_reg;
        c_next           = c_reg;
        ch_next          = ch_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        wrap_next        = wrap_reg;
        ptr_next         = ptr_reg;
        beat_next        = beat_reg;
        phase_next       = phase_reg;
        half_next        = half_reg;
        strip_valid_next = strip_valid_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;
        rd_addr          = SW'(idx_reg);
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = '0;
        div_req          = '0;
        mix_op.w0        = WEIGHT_FULL - e_reg;
        mix_op.x         = start_ch;
        mix_op.w1        = e_reg;
        mix_op.y         = end_ch;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = SW'(in_idx);
                if (s_accept)
                begin
                    idx_next    = in_idx;
                    idx_ok_next = in_idx_ok;
                    colors_next = in_colors;
                    red_next    = '0;
                    green_next  = '0;
                    blue_next   = '0;
                    wrap_next   = 1'b0;
                    ch_next     = '0;
                    ptr_next    = '0;
                    unique case (opcode_t'(s_axis_tuser))
                        OP_EVAL:
                        begin
                            if (in_count == '0)
                            begin
                                state_next = ST_WEIGHT;
                            end
                            else if (in_count >= ignore_period_reg)
                            begin
                                green_next = LEVEL_MAX;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                div_req.num   = in_count;
                                div_req.den   = ignore_period_reg;
                                state_next    = ST_QDIV;
                            end
                        end
                        OP_TICK:
                        begin
                            if (beat_reg != '0)
                            begin
                                beat_next = beat_reg - 1'b1;
                            end
                            half_next = !half_reg;
                            if (half_reg)
                            begin
                                phase_next = phase_reg + 1'b1;
                                wrap_next  = (phase_reg == LEVEL_MAX);
                            end
                            state_next = ST_TICK_RD;
                        end
                        OP_BEAT:
                        begin
                            beat_next  = BEAT_START;
                            state_next = ST_DONE;
                        end
                        OP_RESTART:
                        begin
                            if (in_idx_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = SW'(in_idx);
                                mem_wdata = '0;
                            end
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // green indicator level
            ST_QDIV:
            begin
                if (div_done)
                begin
                    if (div_quot != '0)
                    begin
                        green_next = div_quot;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WEIGHT;
                    end
                end
            end

            // crossfade end weight
            ST_WEIGHT:
            begin
                if (!host_mode_reg)
                begin
                    e_next     = WEIGHT_W'(phase_reg);
                    state_next = ST_BLEND;
                end
                else if (!idx_ok_reg || step_val >= smooth_steps_reg)
                begin
                    if (idx_ok_reg || smooth_steps_reg == '0)
                    begin
                        e_next     = WEIGHT_FULL;
                        state_next = ST_BLEND;
                    end
                    else
                    begin
                        e_next     = '0;
                        state_next = ST_BLEND;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = COUNT_W'(step_val);
                    div_req.den   = COUNT_W'(smooth_steps_reg);
                    state_next    = ST_EDIV;
                end
            end

            ST_EDIV:
            begin
                if (div_done)
                begin
                    e_next     = WEIGHT_W'(div_quot);
                    state_next = ST_BLEND;
                end
            end

            // blend start and end of one channel
            ST_BLEND:
            begin
                c_next     = mix_res;
                state_next = ST_FLASH;
            end

            // lift the blended channel toward white
            ST_FLASH:
            begin
                mix_op.w0 = lift;
                mix_op.x  = LEVEL_MAX;
                mix_op.w1 = WEIGHT_FULL - lift;
                mix_op.y  = c_reg;
                case (ch_reg)
                    2'd0:    red_next   = mix_res;
                    2'd1:    green_next = mix_res;
                    default: blue_next  = mix_res;
                endcase
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_BLEND;
                end
            end

            // walk the strip steps, one read and one write per strip
            ST_TICK_RD:
            begin
                rd_addr    = ptr_reg;
                state_next = ST_TICK_WR;
            end

            ST_TICK_WR:
            begin
                rd_addr   = ptr_reg;
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = (step_val >= smooth_steps_reg) ? smooth_steps_reg
                                                           : step_val + 1'b1;
                if (ptr_reg == LAST_STRIP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_TICK_RD;
                end
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {blue_reg, green_reg, red_reg};
                    m_user_next  = wrap_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_we)
        begin
            strip_valid_next[mem_waddr] = 1'b1;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg        <= '0;
            phase_reg       <= '0;
            half_reg        <= 1'b0;
            strip_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_user_reg      <= 1'b0;
            ch_reg          <= '0;
            ptr_reg         <= '0;
        end
        else
        begin
            beat_reg        <= beat_next;
            phase_reg       <= phase_next;
            half_reg        <= half_next;
            strip_valid_reg <= strip_valid_next;
            rd_valid_reg    <= strip_valid_reg[rd_addr];
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
            m_user_reg      <= m_user_next;
            ch_reg          <= ch_next;
            ptr_reg         <= ptr_next;
        end
    end

    // request payload and working values
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        idx_ok_reg <= idx_ok_next;
        colors_reg <= colors_next;
        e_reg      <= e_next;
        c_reg      <= c_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        wrap_reg   <= wrap_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- src/lccb_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Computes num*256/den for num < den. Depends on lccb_pkg.
`default_nettype none

module lccb_div
    import lccb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire div_req_t            req,
    output logic                     done,
    output logic [DIV_STEPS-1:0]     quot
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    den_reg;
    logic [DIV_STEPS-1:0]  quot_reg;

    logic [COUNT_W:0]      trial;
    logic [COUNT_W:0]      diff;
    logic                  ge;
    logic [COUNT_W-1:0]    rem_next;

    // one restoring step: remainder stays below the divisor
    always_comb
    begin
        trial    = {rem_reg, 1'b0};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end

    // step counter and quotient shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= req.num;
            den_reg  <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIV_STEPS-2:0], ge};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- src/lccb_mix.sv -----
// Shared multiply-add for the crossfade blend and the beat flash.
// Result is (w0*x + w1*y) >> 8. Depends on lccb_pkg.
`default_nettype none

module lccb_mix
    import lccb_pkg::*;
(
    input  wire mix_op_t          op,
    output logic [COLOR_W-1:0]    res
);

    logic [WEIGHT_W+COLOR_W-1:0] p0;
    logic [WEIGHT_W+COLOR_W-1:0] p1;
    logic [15:0]                 sum;

    // weights add up to 256 so the sum stays below 2^16
    always_comb
    begin
        p0  = op.w0 * op.x;
        p1  = op.w1 * op.y;
        sum = 16'(p0 + p1);
        res = sum[15:8];
    end

endmodule

`default_nettype wire

// ----- src/lccb_chk.sv -----
// Port-level checker for led_color_crossfade_beat and its bind statement.
// Depends on lccb_pkg.
`default_nettype none

module lccb_chk
    import lccb_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser
);

    // one request in flight: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    // a new result only comes out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a request in work");

    // mood wrap only comes with a tick, whose color is black
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("mood wrap flagged on a result with color");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind led_color_crossfade_beat lccb_chk u_lccb_chk (.*);

`default_nettype wire

// ----- test/led_color_crossfade_beat_tb.sv -----
`timescale 1ns / 1ps
// Testbench for led_color_crossfade_beat: sends LED requests on the slave stream,
// predicts every color result in step with the block and checks the master stream.
// Depends on lccb_pkg and the led_color_crossfade_beat RTL.

module led_color_crossfade_beat_tb;
    import lccb_pkg::*;

    localparam int STRIP_COUNT     = 8;
    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 300;

    // one LED request, first field in the lowest bits
    typedef struct packed {
        logic [15:0] ignore_count;
        logic [7:0]  end_blue;
        logic [7:0]  end_green;
        logic [7:0]  end_red;
        logic [7:0]  start_blue;
        logic [7:0]  start_green;
        logic [7:0]  start_red;
        logic [2:0]  strip_index;
    } led_req_t;

    // one displayed color plus the mood wrap flag
    typedef struct packed {
        logic       wrap;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } led_color_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // predicted block state and register copies
    logic [7:0]  step_mem [STRIP_COUNT];
    logic [4:0]  beat_lvl;
    logic [7:0]  mood_phase;
    logic        mood_half;
    logic [7:0]  cfg_steps;
    logic        cfg_host;
    logic        cfg_beat;
    logic [15:0] cfg_period;

    led_color_t color_q[$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int errors;
    int cycle_count;
    int results_seen;
    int wraps_predicted;
    int wraps_seen;
    int n_eval;
    int n_tick;
    int n_beat;
    int n_restart;

    led_color_crossfade_beat DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_count, color_q.size());
            $display("led_color_crossfade_beat regression: fail");
            $finish;
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // blend one channel by end weight, then lift toward white on a beat
    function automatic logic [7:0] shade_channel(int unsigned e, logic [7:0] a,
                                                 logic [7:0] b);
        int unsigned c;
        int unsigned lift;
        int unsigned keep;
        c    = ((256 - e) * a + e * b) >> 8;
        lift = 0;
        keep = 256;
        if (cfg_beat)
        begin
            lift = beat_lvl * 2;
            keep = 256 - lift;
            lift = lift * 255;
        end
        return 8'((lift + keep * c) >> 8);
    endfunction

    // advance the predicted state by one request, return the expected result
    function automatic led_color_t apply_request(opcode_t op, led_req_t r);
        led_color_t  res;
        int unsigned q;
        int unsigned e;
        int          i;
        res = '0;
        case (op)
            OP_EVAL:
            begin
                // green indicator level while switches are ignored
                if (cfg_period == 0)
                    q = (r.ignore_count != 0) ? 255 : 0;
                else
                    q = 32'({r.ignore_count, 8'h00}) / 32'(cfg_period);
                if (q > 255)
                    q = 255;
                if (q != 0)
                begin
                    res.green = 8'(q);
                end
                else
                begin
                    if (!cfg_host)
                        e = mood_phase;
                    else if (cfg_steps == 0)
                        e = 256;
                    else
                    begin
                        e = (r.strip_index < STRIP_COUNT) ? step_mem[r.strip_index] : 0;
                        e = (e << 8) / cfg_steps;
                        if (e > 256)
                            e = 256;
                    end
                    res.red   = shade_channel(e, r.start_red, r.end_red);
                    res.green = shade_channel(e, r.start_green, r.end_green);
                    res.blue  = shade_channel(e, r.start_blue, r.end_blue);
                end
            end
            OP_TICK:
            begin
                if (beat_lvl != 0)
                    beat_lvl--;
                for (i = 0; i < STRIP_COUNT; i++)
                begin
                    if (step_mem[i] >= cfg_steps)
                        step_mem[i] = cfg_steps;
                    else
                        step_mem[i]++;
                end
                // mood phase moves every second tick
                if (mood_half)
                begin
                    mood_half  = 1'b0;
                    mood_phase = mood_phase + 8'd1;
                    res.wrap   = (mood_phase == 0);
                end
                else
                begin
                    mood_half = 1'b1;
                end
            end
            OP_BEAT:
            begin
                beat_lvl = BEAT_START;
            end
            default:
            begin
                if (r.strip_index < STRIP_COUNT)
                    step_mem[r.strip_index] = '0;
            end
        endcase
        return res;
    endfunction

    function automatic led_req_t led_req(logic [2:0] strip, logic [23:0] start_rgb,
                                         logic [23:0] end_rgb, logic [15:0] count);
        led_req_t r;
        r.strip_index  = strip;
        r.start_red    = start_rgb[23:16];
        r.start_green  = start_rgb[15:8];
        r.start_blue   = start_rgb[7:0];
        r.end_red      = end_rgb[23:16];
        r.end_green    = end_rgb[15:8];
        r.end_blue     = end_rgb[7:0];
        r.ignore_count = count;
        return r;
    endfunction

    // random colors; the count is mostly zero so the crossfade shows
    function automatic led_req_t random_led_req();
        logic [15:0] count;
        case ($urandom_range(0, 3))
            0, 1:    count = '0;
            2:       count = 16'($urandom_range(0, 400));
            default: count = 16'($urandom_range(0, 65535));
        endcase
        return led_req(3'($urandom_range(0, 7)), 24'($urandom), 24'($urandom), count);
    endfunction

    function automatic opcode_t random_opcode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return OP_EVAL;
        else if (pick < 80)
            return OP_TICK;
        else if (pick < 88)
            return OP_BEAT;
        return OP_RESTART;
    endfunction

    // offer one request, predict its result once accepted
    task automatic send_request(opcode_t op, led_req_t r);
        led_color_t res;
        while ($urandom_range(0, 99) < src_idle_pct)
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W - $bits(led_req_t)){1'b0}}, r};
        s_axis_tuser  = op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = apply_request(op, r);
        color_q.push_back(res);
        if (res.wrap)
            wraps_predicted++;
        case (op)
            OP_EVAL: n_eval++;
            OP_TICK: n_tick++;
            OP_BEAT: n_beat++;
            default: n_restart++;
        endcase
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (color_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_register(cfg_idx_t idx, logic [15:0] value);
        wait_for_drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_SMOOTH_STEPS:  cfg_steps  = value[7:0];
            CFG_HOST_MODE:     cfg_host   = value[0];
            CFG_BEAT_ENABLED:  cfg_beat   = value[0];
            CFG_IGNORE_PERIOD: cfg_period = value;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare every result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        led_color_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (color_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual data %h wrap %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = color_q.pop_front();
                results_seen++;
                if (m_axis_tuser)
                    wraps_seen++;
                check_field("out_red", want.red, m_axis_tdata[7:0]);
                check_field("out_green", want.green, m_axis_tdata[15:8]);
                check_field("out_blue", want.blue, m_axis_tdata[23:16]);
                check_field("mood_wrap", 8'(want.wrap), 8'(m_axis_tuser));
            end
        end
    end

    // defaults after reset: immediate fade, green indicator levels
    task automatic test_reset_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_request(OP_EVAL, led_req(3'd0, 24'h000000, 24'hFFFFFF, 16'd0));
        send_request(OP_EVAL, led_req(3'd7, 24'hFFFFFF, 24'h000000, 16'hFFFF));
        send_request(OP_EVAL, led_req(3'd3, 24'h123456, 24'h654321, 16'd1));
    endtask

    // ignore period extremes, including zero and a quotient that rounds to zero
    task automatic test_ignore_period();
        write_register(CFG_IGNORE_PERIOD, 16'hFFFF);
        send_request(OP_EVAL, led_req(3'd1, 24'hFF00FF, 24'h00FF00, 16'd1));
        send_request(OP_EVAL, led_req(3'd1, 24'hFF00FF, 24'h00FF00, 16'hFFFF));
        write_register(CFG_IGNORE_PERIOD, 16'd0);
        send_request(OP_EVAL, led_req(3'd2, 24'hAA5500, 24'h55AAFF, 16'd0));
        send_request(OP_EVAL, led_req(3'd2, 24'hAA5500, 24'h55AAFF, 16'h8000));
        write_register(CFG_IGNORE_PERIOD, 16'd1);
        send_request(OP_EVAL, led_req(3'd2, 24'hAA5500, 24'h55AAFF, 16'd1));
        write_register(CFG_IGNORE_PERIOD, 16'd100);
    endtask

    // host crossfade walk on one strip, beat flash, step above the step count
    task automatic test_host_fade();
        led_req_t r;
        r = led_req(3'd5, 24'hFF8000, 24'h0040FF, 16'd0);
        write_register(CFG_SMOOTH_STEPS, 16'd4);
        send_request(OP_RESTART, r);
        send_request(OP_EVAL, r);
        send_request(OP_TICK, r);
        send_request(OP_EVAL, r);
        send_request(OP_BEAT, r);
        send_request(OP_TICK, r);
        send_request(OP_EVAL, r);
        write_register(CFG_BEAT_ENABLED, 16'd1);
        send_request(OP_EVAL, r);
        send_request(OP_TICK, r);
        send_request(OP_TICK, r);
        send_request(OP_EVAL, r);
        write_register(CFG_SMOOTH_STEPS, 16'd2);
        send_request(OP_EVAL, r);
        send_request(OP_RESTART, r);
        send_request(OP_EVAL, r);
        write_register(CFG_BEAT_ENABLED, 16'd0);
    endtask

    // mood lamp: tick until the phase wraps, evaluating along the way
    task automatic test_mood_wrap();
        led_req_t r;
        int       wraps_at_start;
        int       k;
        write_register(CFG_HOST_MODE, 16'd0);
        write_register(CFG_BEAT_ENABLED, 16'd1);
        wraps_at_start = wraps_predicted;
        k = 0;
        while (wraps_predicted == wraps_at_start)
        begin
            r = random_led_req();
            if (k % 16 == 0)
            begin
                r.ignore_count = '0;
                send_request(OP_EVAL, r);
            end
            if (k % 64 == 0)
                send_request(OP_BEAT, r);
            send_request(OP_TICK, r);
            k++;
        end
        r.ignore_count = '0;
        send_request(OP_EVAL, r);
        write_register(CFG_BEAT_ENABLED, 16'd0);
        write_register(CFG_HOST_MODE, 16'd1);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_register(CFG_SMOOTH_STEPS, 16'd255);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(negedge clk);
        hold_left = HOLD_OFF_CYCLES;
        repeat (24) send_request(random_opcode(), random_led_req());
        wait_for_drain();
    endtask

    task automatic random_config();
        case ($urandom_range(0, 3))
            0:       write_register(CFG_SMOOTH_STEPS, 16'd0);
            1:       write_register(CFG_SMOOTH_STEPS, 16'd255);
            default: write_register(CFG_SMOOTH_STEPS, 16'($urandom_range(1, 12)));
        endcase
        write_register(CFG_HOST_MODE, 16'($urandom_range(0, 3) != 0));
        write_register(CFG_BEAT_ENABLED, 16'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0:       write_register(CFG_IGNORE_PERIOD, 16'd1);
            1:       write_register(CFG_IGNORE_PERIOD, 16'hFFFF);
            2:       write_register(CFG_IGNORE_PERIOD, 16'd0);
            default: write_register(CFG_IGNORE_PERIOD, 16'($urandom_range(1, 1000)));
        endcase
    endtask

    // random mix of requests under one setting and one idling pattern
    task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
        random_config();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n_items) send_request(random_opcode(), random_led_req());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SMOOTH_STEPS;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_EVAL;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        errors         = 0;
        cycle_count    = 0;
        results_seen   = 0;
        wraps_predicted = 0;
        wraps_seen     = 0;
        n_eval         = 0;
        n_tick         = 0;
        n_beat         = 0;
        n_restart      = 0;

        // state after reset
        foreach (step_mem[i])
            step_mem[i] = '0;
        beat_lvl   = '0;
        mood_phase = '0;
        mood_half  = 1'b0;
        cfg_steps  = 8'd0;
        cfg_host   = 1'b1;
        cfg_beat   = 1'b0;
        cfg_period = 16'd100;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_ignore_period();
        test_host_fade();
        test_mood_wrap();
        test_backpressure();
        test_random_traffic(0, 0, 50);
        test_random_traffic(0, 0, 50);
        test_random_traffic(70, 0, 50);
        test_random_traffic(70, 0, 50);
        test_random_traffic(0, 70, 50);
        test_random_traffic(0, 70, 50);
        test_random_traffic(20, 20, 50);
        test_random_traffic(20, 20, 50);

        // let the last results out
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (color_q.size() != 0)
        begin
            errors += color_q.size();
            $display("%0t: %0d expected results never arrived", $time, color_q.size());
        end

        $display("run covered %0d evaluates, %0d ticks, %0d beats, %0d restarts",
                 n_eval, n_tick, n_beat, n_restart);
        $display("%0d results checked, %0d mood wraps seen, %0d mismatches",
                 results_seen, wraps_seen, errors);
        if (errors == 0)
            $display("led_color_crossfade_beat regression: pass");
        else
            $display("led_color_crossfade_beat regression: fail");
        $finish;
    end

endmodule
